>>> rtl/sha_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash values and round functions.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned RamDepth   = 16;
  localparam int unsigned WordW      = 32;

  localparam logic [7:0] PadByte = 8'h80;
  localparam int unsigned LenPos = 56;

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    unique case (idx)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] idx);
    logic [31:0] h;
    unique case (idx)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

>>> rtl/sha_ram.sv
// ----------------------------------------------------------------------------
// SHA generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module sha_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/sha256_byte_stream_hasher_top.sv
// A request that does not complete a block is taken while idle. The 64th byte starts
// a compression: a load, 16 rounds of a read and a round step, 48 rounds of three
// schedule reads, then read-modify-write, and the hash update. End of message adds
// padding (one byte position per step), the two length words, one or two compressions
// and 8 digest words. No byte is taken while a block is compressed.
// Reset is asynchronous, active low; it restores the initial hash values.
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Collects bytes into words in a schedule memory and runs the compression.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: [7:0] data_byte
  input  logic [7:0]  s_axis_tdata_i,
  // tuser: [0] has_byte
  input  logic        s_axis_tuser_i,
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata: [31:0] digest_word, [34:32] word_index, [39:35] zero
  output logic [39:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o
);

  localparam int unsigned AW = $clog2(sha_pkg::RamDepth);

  localparam logic [3:0] S_IDLE = 4'd0, S_PAD = 4'd1, S_LEN = 4'd2, S_LDH = 4'd3,
    S_RD1 = 4'd4, S_RD2 = 4'd5, S_RD3 = 4'd6, S_RD4 = 4'd7, S_RND = 4'd8,
    S_FIN = 4'd9, S_OUT = 4'd10;

  logic [3:0]  st_q;
  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [31:0] acc_q;          // byte assembly word
  logic [5:0]  fill_q;
  logic [63:0] bits_q;
  logic        fin_q;          // finalize pending
  logic        padded_q;       // 0x80 already placed
  logic [5:0]  rnd_q;
  logic [2:0]  cnt_q;
  logic [31:0] w15_q, w2_q, w7_q;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;

  sha_ram #(.Width(sha_pkg::WordW), .Depth(sha_pkg::RamDepth)) u_wram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  logic acc_in;
  assign acc_in = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (st_q == S_IDLE);

  // Byte insertion into the assembly word at the current fill position.
  function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] p,
                                           input logic [7:0] b);
    logic [31:0] r;
    r = w;
    r[(3 - p) * 8 +: 8] = b;
    return r;
  endfunction

  logic [31:0] wi, t1, t2, mj, ch, wnew;
  always_comb begin
    wnew = rdata + sha_pkg::ssig0(w15_q) + w7_q + sha_pkg::ssig1(w2_q);
    wi   = (rnd_q < 6'd16) ? rdata : wnew;
    ch   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    mj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t1   = v_q[7] + sha_pkg::bsig1(v_q[4]) + ch + sha_pkg::round_k(rnd_q) + wi;
    t2   = sha_pkg::bsig0(v_q[0]) + mj;
  end

  always_comb begin
    we    = 1'b0;
    waddr = fill_q[5:2];
    wdata = acc_q;
    raddr = rnd_q[AW-1:0];
    unique case (st_q)
      S_RD1: raddr = AW'(rnd_q - 6'd15);
      S_RD2: raddr = AW'(rnd_q - 6'd2);
      S_RD3: raddr = AW'(rnd_q - 6'd7);
      S_RND: begin
        if (rnd_q >= 6'd16) begin
          we = 1'b1; waddr = rnd_q[AW-1:0]; wdata = wnew;
        end
      end
      default: ;
    endcase
    if (st_q == S_IDLE && acc_in) begin
      if (s_axis_tuser_i && fill_q[1:0] == 2'd3) begin
        we = 1'b1; wdata = put_byte(acc_q, 2'd3, s_axis_tdata_i);
      end
    end
    if (st_q == S_PAD) begin
      we = (fill_q[1:0] == 2'd3) || (fill_q == 6'(sha_pkg::LenPos - 1)) ||
           (fill_q == 6'(sha_pkg::BlockBytes - 1));
      wdata = padded_q ? acc_q : put_byte(acc_q, fill_q[1:0], sha_pkg::PadByte);
    end
    if (st_q == S_LEN) begin
      we = 1'b1; waddr = cnt_q[0] ? 4'd15 : 4'd14;
      wdata = cnt_q[0] ? bits_q[31:0] : bits_q[63:32];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; fill_q <= '0; bits_q <= '0; fin_q <= 1'b0;
      padded_q <= 1'b0; rnd_q <= '0; cnt_q <= '0; acc_q <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::init_h(3'(i));
    end else begin
      unique case (st_q)
        S_IDLE: if (acc_in) begin
          fin_q <= s_axis_tlast_i;
          if (s_axis_tuser_i) begin
            acc_q  <= (fill_q[1:0] == 2'd3) ? '0
                      : put_byte(acc_q, fill_q[1:0], s_axis_tdata_i);
            bits_q <= bits_q + 64'd8;
            fill_q <= fill_q + 6'd1;
            if (fill_q == 6'd63) begin
              st_q <= S_LDH;
            end else if (s_axis_tlast_i) begin
              st_q <= S_PAD;
            end
          end else if (s_axis_tlast_i) begin
            st_q <= S_PAD;
          end
        end
        S_PAD: begin
          // Place 0x80 at the first free byte, then zeros up to the length.
          acc_q <= (fill_q[1:0] == 2'd3) ? '0
                   : (padded_q ? acc_q : put_byte(acc_q, fill_q[1:0], sha_pkg::PadByte));
          padded_q <= 1'b1;
          fill_q   <= fill_q + 6'd1;
          if (fill_q == 6'd63) begin
            st_q <= S_LDH;
          end else if (fill_q == 6'(sha_pkg::LenPos - 1)) begin
            fill_q <= '0; cnt_q <= '0; st_q <= S_LEN;
          end else if (fill_q[1:0] == 2'd3) begin
            acc_q <= '0;
          end
        end
        S_LEN: begin
          cnt_q <= cnt_q + 3'd1;
          if (cnt_q[0]) begin
            fin_q <= 1'b0; fill_q <= '0; st_q <= S_LDH;
          end
        end
        S_LDH: begin
          for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
          rnd_q <= '0; st_q <= S_RD4; acc_q <= '0;
        end
        S_RD1: begin st_q <= S_RD2; end
        S_RD2: begin w15_q <= rdata; st_q <= S_RD3; end
        S_RD3: begin w2_q <= rdata; st_q <= S_RD4; end
        S_RD4: begin
          if (rnd_q >= 6'd16) w7_q <= rdata;
          st_q <= S_RND;
        end
        S_RND: begin
          v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
          v_q[4] <= v_q[3] + t1; v_q[3] <= v_q[2]; v_q[2] <= v_q[1];
          v_q[1] <= v_q[0]; v_q[0] <= t1 + t2;
          rnd_q <= rnd_q + 6'd1;
          if (rnd_q == 6'd63) st_q <= S_FIN;
          else if (rnd_q >= 6'd15) st_q <= S_RD1;
          else st_q <= S_RD4;
        end
        S_FIN: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
          cnt_q <= '0;
          if (fin_q) st_q <= S_PAD;
          else if (padded_q) st_q <= S_OUT;
          else st_q <= S_IDLE;
        end
        S_OUT: if (m_axis_tready_i) begin
          cnt_q <= cnt_q + 3'd1;
          if (cnt_q == 3'd7) begin
            st_q <= S_IDLE; fill_q <= '0; bits_q <= '0; padded_q <= 1'b0;
            fin_q <= 1'b0; acc_q <= '0;
            for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::init_h(3'(i));
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  // The 64th byte and end-of-message share the same compression; fin_q
  // then sends the machine to padding after the hash update.
  assign m_axis_tvalid_o = (st_q == S_OUT);
  assign m_axis_tdata_o  = {5'd0, cnt_q, h_q[cnt_q]};
  assign m_axis_tlast_o  = (cnt_q == 3'd7);

endmodule

>>> rtl/sha_checker.sv
// ----------------------------------------------------------------------------
// SHA checker
// Port-level properties of the hasher, bound to the top level.
// ----------------------------------------------------------------------------
module sha_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [39:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o) else $error("input taken during output");

  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tlast_o == (m_axis_tdata_o[34:32] == 3'd7)))
    else $error("last flag mismatch");

  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o) |=>
    (m_axis_tvalid_o && m_axis_tdata_o[34:32] == $past(m_axis_tdata_o[34:32]) + 3'd1))
    else $error("word index did not advance");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> $stable(m_axis_tdata_o))
    else $error("stalled output changed");

endmodule

bind sha256_byte_stream_hasher_top sha_checker u_sha_checker (.*);
